@@ rtl/xfse_pkg.sv @@
// Shared types, header codes and the leading-zero bucket table of the XOR float stream encoder.
package xfse_pkg;

  localparam int unsigned SampleWidth  = 64;
  localparam int unsigned HeaderWidth  = 11;
  localparam int unsigned HlenWidth    = 4;
  localparam int unsigned PlenWidth    = 7;
  localparam int unsigned CountWidth   = 7;
  localparam int unsigned IdxWidth     = 3;
  localparam int unsigned CentreWidth  = 6;

  localparam logic [1:0] HdrZero   = 2'b00;
  localparam logic [1:0] HdrCentre = 2'b01;
  localparam logic [1:0] HdrSame   = 2'b10;
  localparam logic [1:0] HdrNew    = 2'b11;

  localparam logic [HlenWidth-1:0] HlenRaw    = 4'd0;
  localparam logic [HlenWidth-1:0] HlenShort  = 4'd2;
  localparam logic [HlenWidth-1:0] HlenNew    = 4'd5;
  localparam logic [HlenWidth-1:0] HlenCentre = 4'd11;

  localparam logic [CountWidth-1:0] WidthFloat  = 7'd32;
  localparam logic [CountWidth-1:0] WidthDouble = 7'd64;
  localparam logic [CountWidth-1:0] TrailLimit  = 7'd6;

  // One classified item as it travels from the front part to the back part.
  typedef struct packed {
    logic [SampleWidth-1:0] bits;        // raw sample at block start, XOR otherwise
    logic                   double_mode;
    logic                   block_start;
    logic                   zero;
    logic [IdxWidth-1:0]    idx;
    logic [CountWidth-1:0]  trail;
  } item_t;

  function automatic logic [4:0] lead_map(input logic [IdxWidth-1:0] idx);
    logic [4:0] r;
    unique case (idx)
      3'd0:    r = 5'd0;
      3'd1:    r = 5'd8;
      3'd2:    r = 5'd12;
      3'd3:    r = 5'd16;
      3'd4:    r = 5'd18;
      3'd5:    r = 5'd20;
      3'd6:    r = 5'd22;
      3'd7:    r = 5'd24;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [CountWidth-1:0] count_trail(input logic [SampleWidth-1:0] v);
    logic [CountWidth-1:0] n;
    n = CountWidth'(SampleWidth);
    for (int i = SampleWidth - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = CountWidth'(i);
      end
    end
    return n;
  endfunction

endpackage

@@ rtl/xfse_if.sv @@
// Stream and configuration channel interfaces of the XOR float stream encoder.
interface xfse_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] sample_bits;
  logic        block_start;

  modport source (output valid, output sample_bits, output block_start, input ready);
  modport sink   (input valid, input sample_bits, input block_start, output ready);
endinterface

interface xfse_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] header_code;
  logic [3:0]  header_len;
  logic [63:0] payload;
  logic [6:0]  payload_len;

  modport source (output valid, output header_code, output header_len, output payload,
                  output payload_len, input ready);
  modport sink   (input valid, input header_code, input header_len, input payload,
                  input payload_len, output ready);
endinterface

interface xfse_cfg_if;
  logic valid;
  logic ready;
  logic double_mode;

  modport source (output valid, output double_mode, input ready);
  modport sink   (input valid, input double_mode, output ready);
endinterface

@@ rtl/xor_float_stream_encoder_unit.sv @@
// Top level of the XOR float stream encoder: front part, queue and back part.
// The block takes one IEEE float or double bit pattern per transfer on in_i and
// returns one codeword per transfer on out_o, as a header with its length and a
// right-aligned payload with its length. The first value of a block is passed raw;
// later values are coded from their XOR with the previous value.
// cfg_i writes the double_mode register and is always ready. It should be written
// only while no transfer is in flight. After reset double_mode is 1, the previous
// value is zero and the stored leading index is zero.
// A result passes from its input transfer through the input register, the two-entry
// queue and the output register, in that order. Throughput is one item per cycle
// while out_o.ready stays high.
// When the receiver stalls, the output register holds its result, the queue fills
// and in_i.ready falls only once the input register can no longer move on.
// Results leave in the order the samples arrived, and none is dropped.
module xor_float_stream_encoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  xfse_in_if.sink    in_i,
  xfse_cfg_if.sink   cfg_i,
  xfse_out_if.source out_o
);

  logic            push_valid;
  logic            push_ready;
  xfse_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  xfse_pkg::item_t pop_item;

  xfse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_item_o  (push_item)
  );

  xfse_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  xfse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

endmodule

@@ rtl/xfse_front.sv @@
// Front part: takes input transfers, forms the XOR against the previous value and classifies it.
module xfse_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  xfse_in_if.sink            in_i,
  xfse_cfg_if.sink           cfg_i,
  input  logic               push_ready_i,
  output logic               push_valid_o,
  output xfse_pkg::item_t    push_item_o
);

  logic                              double_mode_q;
  logic                              valid_q, valid_d;
  logic [xfse_pkg::SampleWidth-1:0]  prev_q, prev_d;
  logic [xfse_pkg::SampleWidth-1:0]  bits_q, bits_d;
  logic                              mode_q, mode_d;
  logic                              start_q, start_d;
  logic [xfse_pkg::SampleWidth-1:0]  wmask;
  logic [xfse_pkg::SampleWidth-1:0]  sample;
  logic [xfse_pkg::SampleWidth-1:0]  aligned;
  logic [xfse_pkg::IdxWidth-1:0]     idx;
  logic                              accept;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !valid_q || push_ready_i;
  assign accept      = in_i.valid && in_i.ready;

  assign wmask  = double_mode_q ? '1 : {32'h0, 32'hFFFF_FFFF};
  assign sample = in_i.sample_bits & wmask;

  always_comb begin
    valid_d = valid_q;
    prev_d  = prev_q;
    bits_d  = bits_q;
    mode_d  = mode_q;
    start_d = start_q;
    if (push_valid_o && push_ready_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
      prev_d  = sample;
      bits_d  = in_i.block_start ? sample : ((sample ^ prev_q) & wmask);
      mode_d  = double_mode_q;
      start_d = in_i.block_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      double_mode_q <= 1'b1;
      valid_q       <= 1'b0;
      prev_q        <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        double_mode_q <= cfg_i.double_mode;
      end
      valid_q <= valid_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q  <= bits_d;
    mode_q  <= mode_d;
    start_q <= start_d;
  end

  // The leading-zero bucket is the highest table entry whose top bits are all clear.
  assign aligned = mode_q ? bits_q : {bits_q[31:0], 32'h0};

  always_comb begin
    idx = '0;
    for (int i = 1; i < 8; i++) begin
      if ((aligned >> (xfse_pkg::SampleWidth - 32'(xfse_pkg::lead_map(3'(i))))) == '0) begin
        idx = 3'(i);
      end
    end
  end

  assign push_valid_o            = valid_q;
  assign push_item_o.bits        = bits_q;
  assign push_item_o.double_mode = mode_q;
  assign push_item_o.block_start = start_q;
  assign push_item_o.zero        = (bits_q == '0);
  assign push_item_o.idx         = idx;
  assign push_item_o.trail       = xfse_pkg::count_trail(bits_q);

endmodule

@@ rtl/xfse_fifo.sv @@
// Two-entry queue that decouples the front part from the back part.
module xfse_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  xfse_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output xfse_pkg::item_t pop_item_o
);

  xfse_pkg::item_t mem_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push;
  logic            pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/xfse_back.sv @@
// Back part: builds header and payload for each classified item and holds the output register.
module xfse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  xfse_pkg::item_t pop_item_i,
  xfse_out_if.source      out_o
);

  logic                                valid_q;
  logic [xfse_pkg::IdxWidth-1:0]       lead_idx_q, lead_idx_d;
  logic [xfse_pkg::HeaderWidth-1:0]    hcode_q, hcode_d;
  logic [xfse_pkg::HlenWidth-1:0]      hlen_q, hlen_d;
  logic [xfse_pkg::SampleWidth-1:0]    payload_q, payload_d;
  logic [xfse_pkg::PlenWidth-1:0]      plen_q, plen_d;
  logic [xfse_pkg::CountWidth-1:0]     width;
  logic [xfse_pkg::CountWidth-1:0]     span;
  logic [xfse_pkg::CountWidth-1:0]     centre;
  logic                                pop;

  assign pop_ready_o = !valid_q || out_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  assign width  = pop_item_i.double_mode ? xfse_pkg::WidthDouble : xfse_pkg::WidthFloat;
  assign span   = width - {2'b0, xfse_pkg::lead_map(pop_item_i.idx)};
  assign centre = span - pop_item_i.trail;

  always_comb begin
    lead_idx_d = lead_idx_q;
    hcode_d    = '0;
    hlen_d     = xfse_pkg::HlenRaw;
    payload_d  = '0;
    plen_d     = '0;
    if (pop_item_i.block_start) begin
      payload_d  = pop_item_i.bits;
      plen_d     = width;
      lead_idx_d = '0;
    end else if (pop_item_i.zero) begin
      hcode_d = {9'b0, xfse_pkg::HdrZero};
      hlen_d  = xfse_pkg::HlenShort;
    end else begin
      lead_idx_d = pop_item_i.idx;
      if (pop_item_i.trail > xfse_pkg::TrailLimit) begin
        hcode_d   = {xfse_pkg::HdrCentre, pop_item_i.idx, centre[xfse_pkg::CentreWidth-1:0]};
        hlen_d    = xfse_pkg::HlenCentre;
        payload_d = pop_item_i.bits >> pop_item_i.trail;
        plen_d    = centre;
      end else begin
        if (pop_item_i.idx == lead_idx_q) begin
          hcode_d = {9'b0, xfse_pkg::HdrSame};
          hlen_d  = xfse_pkg::HlenShort;
        end else begin
          hcode_d = {6'b0, xfse_pkg::HdrNew, pop_item_i.idx};
          hlen_d  = xfse_pkg::HlenNew;
        end
        payload_d = pop_item_i.bits;
        plen_d    = span;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      lead_idx_q <= '0;
    end else begin
      if (pop) begin
        valid_q    <= 1'b1;
        lead_idx_q <= lead_idx_d;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      hcode_q   <= hcode_d;
      hlen_q    <= hlen_d;
      payload_q <= payload_d;
      plen_q    <= plen_d;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.header_code = hcode_q;
  assign out_o.header_len  = hlen_q;
  assign out_o.payload     = payload_q;
  assign out_o.payload_len = plen_q;

endmodule
